@@ src/pcn_pkg.sv @@
// Package for the profile crease normal block.
// Holds widths, the Q2.14 unit constant and the tag carried beside the normalizers.
// No dependencies.
package pcn_pkg;

  localparam int PW = 32;
  localparam int NW = 16;
  localparam int VW = 34;
  localparam int SW = 31;
  localparam int SQ_STEPS = 32;
  localparam int DIV_BITS = 15;
  localparam int DW = 46;
  localparam int UNIT_SHIFT = 14;

  typedef struct packed {
    logic                 vld;
    logic                 end_side;
    logic                 smooth;
    logic                 degen;
    logic signed [NW-1:0] rx;
    logic signed [NW-1:0] ry;
  } pcn_tag_t;

  typedef struct packed {
    logic signed [NW-1:0] nx;
    logic signed [NW-1:0] ny;
    logic                 smooth;
    logic                 degen;
  } pcn_res_t;

endpackage

@@ src/pcn_in_if.sv @@
// Input channel of the profile crease normal block: three profile points and a side flag.
// Depends on pcn_pkg.
interface pcn_in_if;
  logic                          valid;
  logic                          ready;
  logic signed [pcn_pkg::PW-1:0] prev_x;
  logic signed [pcn_pkg::PW-1:0] prev_y;
  logic signed [pcn_pkg::PW-1:0] cur_x;
  logic signed [pcn_pkg::PW-1:0] cur_y;
  logic signed [pcn_pkg::PW-1:0] next_x;
  logic signed [pcn_pkg::PW-1:0] next_y;
  logic                          end_side;

  modport source (output valid, prev_x, prev_y, cur_x, cur_y, next_x, next_y, end_side,
                  input ready);
  modport sink (input valid, prev_x, prev_y, cur_x, cur_y, next_x, next_y, end_side,
                output ready);
endinterface

@@ src/pcn_out_if.sv @@
// Output channel of the profile crease normal block: Q2.14 normal and status flags.
// Depends on pcn_pkg.
interface pcn_out_if;
  logic                          valid;
  logic                          ready;
  logic signed [pcn_pkg::NW-1:0] normal_x;
  logic signed [pcn_pkg::NW-1:0] normal_y;
  logic                          smooth;
  logic                          degenerate;

  modport source (output valid, normal_x, normal_y, smooth, degenerate, input ready);
  modport sink (input valid, normal_x, normal_y, smooth, degenerate, output ready);
endinterface

@@ src/pcn_unit.sv @@
// Pipelined fixed-point vector normalizer: leading-one scaling, bit-pair square root
// and restoring division, one step per stage. Depends on pcn_pkg.
module pcn_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic signed [pcn_pkg::VW-1:0] a_i,
  input  logic signed [pcn_pkg::VW-1:0] b_i,
  input  pcn_pkg::pcn_tag_t             tag_i,
  output logic signed [pcn_pkg::NW-1:0] x_o,
  output logic signed [pcn_pkg::NW-1:0] y_o,
  output logic                          ok_o,
  output pcn_pkg::pcn_tag_t             tag_o
);

  typedef struct packed {
    logic [pcn_pkg::VW-1:0] ua;
    logic [pcn_pkg::VW-1:0] ub;
    logic                   sa;
    logic                   sb;
    pcn_pkg::pcn_tag_t      tag;
  } wide_t;

  typedef struct packed {
    logic [pcn_pkg::SW-1:0] ua;
    logic [pcn_pkg::SW-1:0] ub;
    logic                   sa;
    logic                   sb;
    logic                   nz;
    pcn_pkg::pcn_tag_t      tag;
  } carry_t;

  wide_t                  s1_q, s2_q;
  logic                   s2_right_q;
  logic [5:0]             s2_amt_q;
  logic [pcn_pkg::VW-1:0] s1_m_q;
  carry_t                 s3_q, s4_q;
  logic [2*pcn_pkg::SW-1:0] s4_sqa_q, s4_sqb_q;

  carry_t     sq_c  [0:pcn_pkg::SQ_STEPS];
  logic [63:0] sq_v [0:pcn_pkg::SQ_STEPS];
  logic [63:0] sq_r [0:pcn_pkg::SQ_STEPS];

  carry_t                         dv_c [0:pcn_pkg::DIV_BITS];
  logic [31:0]                    dv_n [0:pcn_pkg::DIV_BITS];
  logic [pcn_pkg::DW-1:0]         dv_ra [0:pcn_pkg::DIV_BITS];
  logic [pcn_pkg::DW-1:0]         dv_rb [0:pcn_pkg::DIV_BITS];
  logic [pcn_pkg::DIV_BITS-1:0]   dv_qa [0:pcn_pkg::DIV_BITS];
  logic [pcn_pkg::DIV_BITS-1:0]   dv_qb [0:pcn_pkg::DIV_BITS];

  logic signed [pcn_pkg::NW-1:0] x_q, y_q;
  logic                          ok_q;
  pcn_pkg::pcn_tag_t             tag_q;

  // Stage 1: magnitudes and the larger of the two.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= '0;
      s1_m_q <= '0;
    end else if (en_i) begin
      s1_q.sa  <= a_i[pcn_pkg::VW-1];
      s1_q.sb  <= b_i[pcn_pkg::VW-1];
      s1_q.ua  <= a_i[pcn_pkg::VW-1] ? (~a_i + 1'b1) : a_i;
      s1_q.ub  <= b_i[pcn_pkg::VW-1] ? (~b_i + 1'b1) : b_i;
      s1_q.tag <= tag_i;
      s1_m_q   <= ((a_i[pcn_pkg::VW-1] ? (~a_i + 1'b1) : a_i) >
                   (b_i[pcn_pkg::VW-1] ? (~b_i + 1'b1) : b_i)) ?
                  (a_i[pcn_pkg::VW-1] ? (~a_i + 1'b1) : a_i) :
                  (b_i[pcn_pkg::VW-1] ? (~b_i + 1'b1) : b_i);
    end
  end

  // Stage 2: leading-one position and scaling shift.
  logic [5:0] msb_pos;
  always_comb begin
    msb_pos = '0;
    for (int i = 0; i < pcn_pkg::VW; i++) begin
      if (s1_m_q[i]) msb_pos = 6'(i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q       <= '0;
      s2_right_q <= 1'b0;
      s2_amt_q   <= '0;
    end else if (en_i) begin
      s2_q       <= s1_q;
      s2_right_q <= (msb_pos > 6'(pcn_pkg::SW - 1));
      s2_amt_q   <= (msb_pos > 6'(pcn_pkg::SW - 1)) ? (msb_pos - 6'(pcn_pkg::SW - 1)) :
                                                      (6'(pcn_pkg::SW - 1) - msb_pos);
    end
  end

  // Stage 3: apply the common shift.
  logic [pcn_pkg::VW-1:0] sh_a, sh_b;
  assign sh_a = s2_right_q ? (s2_q.ua >> s2_amt_q) : (s2_q.ua << s2_amt_q);
  assign sh_b = s2_right_q ? (s2_q.ub >> s2_amt_q) : (s2_q.ub << s2_amt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_q <= '0;
    end else if (en_i) begin
      s3_q.ua  <= sh_a[pcn_pkg::SW-1:0];
      s3_q.ub  <= sh_b[pcn_pkg::SW-1:0];
      s3_q.sa  <= s2_q.sa;
      s3_q.sb  <= s2_q.sb;
      s3_q.nz  <= (s2_q.ua != '0) || (s2_q.ub != '0);
      s3_q.tag <= s2_q.tag;
    end
  end

  // Stage 4: squares.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_q     <= '0;
      s4_sqa_q <= '0;
      s4_sqb_q <= '0;
    end else if (en_i) begin
      s4_q     <= s3_q;
      s4_sqa_q <= s3_q.ua * s3_q.ua;
      s4_sqb_q <= s3_q.ub * s3_q.ub;
    end
  end

  // Stage 5: sum of squares feeds the root.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_c[0] <= '0;
      sq_v[0] <= '0;
      sq_r[0] <= '0;
    end else if (en_i) begin
      sq_c[0] <= s4_q;
      sq_v[0] <= 64'(s4_sqa_q) + 64'(s4_sqb_q);
      sq_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < pcn_pkg::SQ_STEPS; k++) begin : g_sqrt
    localparam logic [63:0] Bit = 64'(1) << (62 - 2 * k);
    logic [63:0] trial;
    assign trial = sq_r[k] + Bit;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_c[k+1] <= '0;
        sq_v[k+1] <= '0;
        sq_r[k+1] <= '0;
      end else if (en_i) begin
        sq_c[k+1] <= sq_c[k];
        if (sq_v[k] >= trial) begin
          sq_v[k+1] <= sq_v[k] - trial;
          sq_r[k+1] <= (sq_r[k] >> 1) + Bit;
        end else begin
          sq_v[k+1] <= sq_v[k];
          sq_r[k+1] <= sq_r[k] >> 1;
        end
      end
    end
  end

  // Division setup: rounded numerators.
  logic [31:0] root;
  assign root = sq_r[pcn_pkg::SQ_STEPS][31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_c[0]  <= '0;
      dv_n[0]  <= '0;
      dv_ra[0] <= '0;
      dv_rb[0] <= '0;
      dv_qa[0] <= '0;
      dv_qb[0] <= '0;
    end else if (en_i) begin
      dv_c[0]  <= sq_c[pcn_pkg::SQ_STEPS];
      dv_n[0]  <= root;
      dv_ra[0] <= (pcn_pkg::DW'(sq_c[pcn_pkg::SQ_STEPS].ua) << pcn_pkg::UNIT_SHIFT) +
                  pcn_pkg::DW'(root >> 1);
      dv_rb[0] <= (pcn_pkg::DW'(sq_c[pcn_pkg::SQ_STEPS].ub) << pcn_pkg::UNIT_SHIFT) +
                  pcn_pkg::DW'(root >> 1);
      dv_qa[0] <= '0;
      dv_qb[0] <= '0;
    end
  end

  for (genvar j = 0; j < pcn_pkg::DIV_BITS; j++) begin : g_div
    localparam int Sh = pcn_pkg::DIV_BITS - 1 - j;
    logic [pcn_pkg::DW-1:0] dsr;
    assign dsr = pcn_pkg::DW'(dv_n[j]) << Sh;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_c[j+1]  <= '0;
        dv_n[j+1]  <= '0;
        dv_ra[j+1] <= '0;
        dv_rb[j+1] <= '0;
        dv_qa[j+1] <= '0;
        dv_qb[j+1] <= '0;
      end else if (en_i) begin
        dv_c[j+1]  <= dv_c[j];
        dv_n[j+1]  <= dv_n[j];
        dv_ra[j+1] <= (dv_ra[j] >= dsr) ? (dv_ra[j] - dsr) : dv_ra[j];
        dv_rb[j+1] <= (dv_rb[j] >= dsr) ? (dv_rb[j] - dsr) : dv_rb[j];
        dv_qa[j+1] <= dv_qa[j] | ((dv_ra[j] >= dsr) ? (pcn_pkg::DIV_BITS'(1) << Sh) : '0);
        dv_qb[j+1] <= dv_qb[j] | ((dv_rb[j] >= dsr) ? (pcn_pkg::DIV_BITS'(1) << Sh) : '0);
      end
    end
  end

  // Final stage: restore signs.
  carry_t                        fin_c;
  logic signed [pcn_pkg::NW-1:0] qa_s, qb_s;
  assign fin_c = dv_c[pcn_pkg::DIV_BITS];
  assign qa_s  = pcn_pkg::NW'(dv_qa[pcn_pkg::DIV_BITS]);
  assign qb_s  = pcn_pkg::NW'(dv_qb[pcn_pkg::DIV_BITS]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q   <= '0;
      y_q   <= '0;
      ok_q  <= 1'b0;
      tag_q <= '0;
    end else if (en_i) begin
      x_q   <= !fin_c.nz ? '0 : (fin_c.sa ? -qa_s : qa_s);
      y_q   <= !fin_c.nz ? '0 : (fin_c.sb ? -qb_s : qb_s);
      ok_q  <= fin_c.nz;
      tag_q <= fin_c.tag;
    end
  end

  assign x_o   = x_q;
  assign y_o   = y_q;
  assign ok_o  = ok_q;
  assign tag_o = tag_q;

endmodule

@@ src/profile_crease_normal_top.sv @@
// Top level of the profile crease normal block: input differences, two segment
// normalizers, crease test, sum normalizer and a two-entry output buffer.
// Depends on pcn_pkg, pcn_in_if, pcn_out_if and pcn_unit.
//
//  channel   direction  contents
//  req_i     in         prev/cur/next points (Q16.16), end_side
//  rsp_o     out        normal_x, normal_y (Q2.14), smooth, degenerate
//  cfg       in         cfg_we_i, cfg_wdata_i: smooth_cos (Q2.14)
//
// One request is taken every cycle unless the pipeline holds; each request passes through
// two 54-stage normalizers in series (32 root steps and 15 divide steps each).
// Reset clears all valid bits and sets smooth_cos to zero.
// The pipeline holds only when both output buffer entries are full and not taken.
module profile_crease_normal_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic signed [pcn_pkg::NW-1:0] cfg_wdata_i,
  pcn_in_if.sink                        req_i,
  pcn_out_if.source                     rsp_o
);

  logic signed [pcn_pkg::NW-1:0] smooth_cos_q;
  logic                          en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_cos_q <= '0;
    end else if (cfg_we_i) begin
      smooth_cos_q <= cfg_wdata_i;
    end
  end

  // Input stage: segment perpendicular components.
  logic signed [pcn_pkg::VW-1:0] a1_q, b1_q, a2_q, b2_q;
  pcn_pkg::pcn_tag_t             in_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_tag_q <= '0;
      a1_q     <= '0;
      b1_q     <= '0;
      a2_q     <= '0;
      b2_q     <= '0;
    end else if (en) begin
      in_tag_q.vld      <= req_i.valid;
      in_tag_q.end_side <= req_i.end_side;
      in_tag_q.smooth   <= 1'b0;
      in_tag_q.degen    <= 1'b0;
      in_tag_q.rx       <= '0;
      in_tag_q.ry       <= '0;
      a1_q <= pcn_pkg::VW'(req_i.cur_y) - pcn_pkg::VW'(req_i.prev_y);
      b1_q <= pcn_pkg::VW'(req_i.prev_x) - pcn_pkg::VW'(req_i.cur_x);
      a2_q <= pcn_pkg::VW'(req_i.next_y) - pcn_pkg::VW'(req_i.cur_y);
      b2_q <= pcn_pkg::VW'(req_i.cur_x) - pcn_pkg::VW'(req_i.next_x);
    end
  end

  logic signed [pcn_pkg::NW-1:0] v1x, v1y, v2x, v2y;
  logic                          ok1, ok2;
  pcn_pkg::pcn_tag_t             tag_a, tag_a_out;

  pcn_unit u_seg_in (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
    .a_i (a1_q), .b_i (b1_q), .tag_i (in_tag_q),
    .x_o (v1x), .y_o (v1y), .ok_o (ok1), .tag_o (tag_a)
  );

  pcn_unit u_seg_out (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
    .a_i (a2_q), .b_i (b2_q), .tag_i (in_tag_q),
    .x_o (v2x), .y_o (v2y), .ok_o (ok2), .tag_o (tag_a_out)
  );

  // Dot product, first half: products.
  logic signed [29:0]            px_q, py_q;
  logic signed [pcn_pkg::NW-1:0] d1_v1x_q, d1_v1y_q, d1_v2x_q, d1_v2y_q;
  logic                          d1_ok_q;
  pcn_pkg::pcn_tag_t             d1_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_tag_q <= '0;
      d1_ok_q  <= 1'b0;
      px_q     <= '0;
      py_q     <= '0;
      d1_v1x_q <= '0;
      d1_v1y_q <= '0;
      d1_v2x_q <= '0;
      d1_v2y_q <= '0;
    end else if (en) begin
      d1_tag_q <= tag_a;
      d1_ok_q  <= ok1 && ok2;
      px_q     <= 30'(v1x * v2x);
      py_q     <= 30'(v1y * v2y);
      d1_v1x_q <= v1x;
      d1_v1y_q <= v1y;
      d1_v2x_q <= v2x;
      d1_v2y_q <= v2y;
    end
  end

  // Dot product, second half: crease test and selection.
  logic signed [31:0] dot, thr;
  logic               is_smooth;
  assign dot       = 32'(px_q) + 32'(py_q);
  assign thr       = 32'(smooth_cos_q) <<< pcn_pkg::UNIT_SHIFT;
  assign is_smooth = d1_ok_q && (dot > thr);

  logic signed [pcn_pkg::VW-1:0] sx_q, sy_q;
  pcn_pkg::pcn_tag_t             d2_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d2_tag_q <= '0;
      sx_q     <= '0;
      sy_q     <= '0;
    end else if (en) begin
      d2_tag_q.vld      <= d1_tag_q.vld;
      d2_tag_q.end_side <= d1_tag_q.end_side;
      d2_tag_q.smooth   <= is_smooth;
      d2_tag_q.degen    <= !d1_ok_q;
      d2_tag_q.rx       <= !d1_ok_q ? '0 : (d1_tag_q.end_side ? d1_v1x_q : d1_v2x_q);
      d2_tag_q.ry       <= !d1_ok_q ? '0 : (d1_tag_q.end_side ? d1_v1y_q : d1_v2y_q);
      sx_q <= pcn_pkg::VW'(d1_v1x_q) + pcn_pkg::VW'(d1_v2x_q);
      sy_q <= pcn_pkg::VW'(d1_v1y_q) + pcn_pkg::VW'(d1_v2y_q);
    end
  end

  logic signed [pcn_pkg::NW-1:0] ux, uy;
  logic                          ok3;
  pcn_pkg::pcn_tag_t             tag_b;

  pcn_unit u_sum (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
    .a_i (sx_q), .b_i (sy_q), .tag_i (d2_tag_q),
    .x_o (ux), .y_o (uy), .ok_o (ok3), .tag_o (tag_b)
  );

  pcn_pkg::pcn_res_t res_new;
  always_comb begin
    res_new.smooth = tag_b.smooth;
    if (tag_b.smooth) begin
      res_new.nx    = ux;
      res_new.ny    = uy;
      res_new.degen = !ok3;
    end else begin
      res_new.nx    = tag_b.rx;
      res_new.ny    = tag_b.ry;
      res_new.degen = tag_b.degen;
    end
  end

  // Two-entry output buffer.
  pcn_pkg::pcn_res_t e0_q, e1_q;
  logic [1:0]        cnt_q;
  logic              push, pop;

  assign en    = (cnt_q != 2'd2) || rsp_o.ready;
  assign push  = en && tag_b.vld;
  assign pop   = rsp_o.valid && rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      e0_q  <= '0;
      e1_q  <= '0;
    end else begin
      unique case ({push, pop})
        2'b10: begin
          if (cnt_q == 2'd0) e0_q <= res_new;
          else e1_q <= res_new;
          cnt_q <= cnt_q + 2'd1;
        end
        2'b01: begin
          e0_q  <= e1_q;
          cnt_q <= cnt_q - 2'd1;
        end
        2'b11: begin
          if (cnt_q == 2'd1) begin
            e0_q <= res_new;
          end else begin
            e0_q <= e1_q;
            e1_q <= res_new;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign req_i.ready      = en;
  assign rsp_o.valid      = (cnt_q != 2'd0);
  assign rsp_o.normal_x   = e0_q.nx;
  assign rsp_o.normal_y   = e0_q.ny;
  assign rsp_o.smooth     = e0_q.smooth;
  assign rsp_o.degenerate = e0_q.degen;

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("output buffer count out of range");

  a_tags_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag_a == tag_a_out) else $error("segment normalizers out of step");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.degenerate |-> rsp_o.normal_x == 0 && rsp_o.normal_y == 0)
    else $error("degenerate result with nonzero normal");

  a_crease_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.degenerate |-> rsp_o.normal_x != 0 || rsp_o.normal_y != 0)
    else $error("regular result with zero normal");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> rsp_o.normal_x <= 16384 && rsp_o.normal_x >= -16384 &&
                    rsp_o.normal_y <= 16384 && rsp_o.normal_y >= -16384)
    else $error("normal component beyond unit length");
`endif

endmodule
